// ----- hdl/cpc_pkg.sv -----
// Package: shared types, constants and helper functions for the cursor pixel converter.
`default_nettype none

package cpc_pkg;

    // Palette store geometry
    localparam int LOW_SLOT_COUNT  = 10;
    localparam int HIGH_SLOT_START = 246;
    localparam int STORE_DEPTH     = LOW_SLOT_COUNT + 256 - HIGH_SLOT_START;
    localparam int IDX_W           = $clog2(STORE_DEPTH);
    localparam int CNT_W           = $clog2(STORE_DEPTH + 1);

    // Distances never exceed 3*255, so 10 bits suffice
    localparam int DIST_W = 10;

    // Operation codes
    localparam logic OP_CONVERT = 1'b0;
    localparam logic OP_LOAD    = 1'b1;

    // Conversion modes (three behaves as direct)
    localparam logic [1:0] MODE_MONO    = 2'd0;
    localparam logic [1:0] MODE_PALETTE = 2'd1;
    localparam logic [1:0] MODE_DIRECT  = 2'd2;

    // Register indexes
    localparam logic REG_CONVERSION_MODE = 1'b0;

    // Mono mode thresholds
    localparam logic [7:0]  MONO_MASK_ALPHA = 8'd10;
    localparam logic [11:0] LEVEL_STEP      = 12'd766;

    typedef struct packed {
        logic       operation;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [5:0] column;
        logic [5:0] image_row;
        logic [7:0] palette_slot;
    } pixel_t;

    typedef struct packed {
        logic        mask_bit;
        logic        xor_bit;
        logic [31:0] color_word;
    } result_t;

    // Sequencer to search unit
    typedef struct packed {
        logic             clear;
        logic             step;
        logic [IDX_W-1:0] index;
    } search_ctrl_t;

    function automatic logic [7:0] dither_pattern(input logic [2:0] level);
        logic [7:0] pat;
        case (level)
            3'd0:    pat = 8'h00;
            3'd1:    pat = 8'h11;
            3'd2:    pat = 8'h55;
            3'd3:    pat = 8'h77;
            default: pat = 8'hff;
        endcase
        return pat;
    endfunction

    function automatic logic [7:0] slot_of_entry(input logic [IDX_W-1:0] e);
        logic [7:0] slot;
        if (int'(e) < LOW_SLOT_COUNT) begin
            slot = 8'(e);
        end else begin
            slot = 8'(HIGH_SLOT_START) + 8'(e) - 8'(LOW_SLOT_COUNT);
        end
        return slot;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/cpc_palette_store.sv -----
// Palette store: register file of RGB entries, cleared at reset, registered read.
`default_nettype none

module cpc_palette_store (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     wr_en,
    input  wire logic [cpc_pkg::IDX_W-1:0] wr_addr,
    input  wire logic [23:0]              wr_data,
    input  wire logic [cpc_pkg::IDX_W-1:0] rd_addr,
    output logic      [23:0]              rd_data_reg
);

    logic [23:0] entry_reg [cpc_pkg::STORE_DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < cpc_pkg::STORE_DEPTH; i++) begin
                entry_reg[i] <= '0;
            end
        end else if (wr_en) begin
            entry_reg[wr_addr] <= wr_data;
        end
    end

    // rd_addr only ever runs below the depth
    always_ff @(posedge aclk) begin
        rd_data_reg <= entry_reg[rd_addr];
    end

endmodule

`default_nettype wire

// ----- hdl/cpc_search_unit.sv -----
// Shared distance unit: Manhattan distance of one entry per cycle, keeps running minimum.
`default_nettype none

module cpc_search_unit (
    input  wire logic                         aclk,
    input  wire cpc_pkg::search_ctrl_t        ctrl,
    input  wire logic [7:0]                   red,
    input  wire logic [7:0]                   green,
    input  wire logic [7:0]                   blue,
    input  wire logic [23:0]                  entry,
    output logic      [cpc_pkg::IDX_W-1:0]    best_index_reg
);

    logic [cpc_pkg::DIST_W-1:0] best_dist_reg;
    logic [7:0]                 diff_r, diff_g, diff_b;
    logic [cpc_pkg::DIST_W-1:0] cur_dist;

    always_comb begin
        diff_r   = (red   > entry[23:16]) ? red   - entry[23:16] : entry[23:16] - red;
        diff_g   = (green > entry[15:8])  ? green - entry[15:8]  : entry[15:8]  - green;
        diff_b   = (blue  > entry[7:0])   ? blue  - entry[7:0]   : entry[7:0]   - blue;
        cur_dist = cpc_pkg::DIST_W'(diff_r) + cpc_pkg::DIST_W'(diff_g)
                 + cpc_pkg::DIST_W'(diff_b);
    end

    // Strict less-than: earliest entry wins a tie. All-ones start beats no real distance.
    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            best_dist_reg  <= '1;
            best_index_reg <= '0;
        end else if (ctrl.step && (cur_dist < best_dist_reg)) begin
            best_dist_reg  <= cur_dist;
            best_index_reg <= ctrl.index;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/cursor_pixel_converter.sv -----
// Top level: cursor pixel converter with sequencer, configuration port and output register.
//
//  channel  | ports              | direction | word
//  ---------+--------------------+-----------+------------------------------------
//  input    | s_valid/s_ready    | in        | cpc_pkg::pixel_t (convert or load)
//  result   | m_valid/m_ready    | out       | cpc_pkg::result_t, one per convert
//  config   | psel/penable/...   | in        | conversion_mode at byte address 0
//
//  Load words are written to the store in the accept cycle; the block is ready again next.
//  Mono and direct words: result computed at accept and registered, then handed to the
//  output register from the finish state once it is free; the next word goes in after.
//  Palette words: the shared distance unit walks the 20 stored entries, one a cycle,
//  behind the store's registered read; the search state then hands over to the finish
//  state, which loads the output register once it is free and then returns to idle.
//  Reset (aresetn low, synchronous) clears the store, the mode and all control state.
//  A result waiting on m_ready does not block the next accept; only a second finished
//  result holds in the finish state until the output register frees.
`default_nettype none

module cursor_pixel_converter (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire cpc_pkg::pixel_t  s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output cpc_pkg::result_t      m_data,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic      [31:0]      prdata,
    output logic                  pready
);

    // Sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [cpc_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [1:0]                  mode_reg;
    cpc_pkg::pixel_t             pix_reg;
    cpc_pkg::result_t            res_reg;
    cpc_pkg::result_t            out_reg;
    logic                        out_valid_reg;

    logic                        s_accept;
    logic                        out_load;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= cpc_pkg::MODE_MONO;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == cpc_pkg::REG_CONVERSION_MODE)) begin
            mode_reg <= pwdata[1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == cpc_pkg::REG_CONVERSION_MODE) begin
            prdata = {30'd0, mode_reg};
        end
    end

    // ---------------- input side ----------------
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;

    // Slot to store entry mapping; slots in the gap are dropped
    logic                      slot_low, slot_high;
    logic [cpc_pkg::IDX_W-1:0] wr_addr;
    logic                      wr_en;

    always_comb begin
        slot_low  = (int'(s_data.palette_slot) < cpc_pkg::LOW_SLOT_COUNT);
        slot_high = (int'(s_data.palette_slot) >= cpc_pkg::HIGH_SLOT_START);
        if (slot_low) begin
            wr_addr = cpc_pkg::IDX_W'(s_data.palette_slot);
        end else begin
            wr_addr = cpc_pkg::IDX_W'(cpc_pkg::LOW_SLOT_COUNT)
                    + cpc_pkg::IDX_W'(s_data.palette_slot - 8'(cpc_pkg::HIGH_SLOT_START));
        end
        wr_en = s_accept && (s_data.operation == cpc_pkg::OP_LOAD) && (slot_low || slot_high);
    end

    // ---------------- mono / direct result at accept ----------------
    logic [9:0]  sum_rgb;
    logic [11:0] bright;
    logic [2:0]  level;
    logic [2:0]  phase;
    logic [7:0]  pattern;
    cpc_pkg::result_t quick_res;

    always_comb begin
        sum_rgb = 10'(s_data.red) + 10'(s_data.green) + 10'(s_data.blue);
        bright  = {sum_rgb, 2'b00} + 12'(sum_rgb);
        // (sum*5)/766 by threshold compares; at most 4 for any 8-bit inputs
        level   = 3'(bright >= cpc_pkg::LEVEL_STEP)
                + 3'(bright >= 12'(2 * 766))
                + 3'(bright >= 12'(3 * 766))
                + 3'(bright >= 12'(4 * 766));
        phase   = s_data.column[2:0] + s_data.image_row[2:0];
        pattern = cpc_pkg::dither_pattern(level);

        quick_res = '0;
        case (mode_reg)
            cpc_pkg::MODE_MONO: begin
                if (s_data.alpha < cpc_pkg::MONO_MASK_ALPHA) begin
                    quick_res.mask_bit = 1'b1;
                end else begin
                    quick_res.xor_bit = pattern[phase];
                end
            end
            cpc_pkg::MODE_PALETTE: begin
                quick_res.mask_bit = (s_data.alpha == 8'd0);
            end
            default: begin
                quick_res.color_word = {s_data.alpha, s_data.red, s_data.green, s_data.blue};
            end
        endcase
    end

    // ---------------- store and search unit ----------------
    logic [23:0]               entry_data;
    logic [cpc_pkg::IDX_W-1:0] rd_addr;
    logic [cpc_pkg::IDX_W-1:0] best_index;
    cpc_pkg::search_ctrl_t     search_ctrl;

    // Read address leads the processed index by one: store read is registered.
    // Once the count reaches the depth the read parks on entry 0.
    assign rd_addr = (cnt_reg < cpc_pkg::CNT_W'(cpc_pkg::STORE_DEPTH))
                   ? cnt_reg[cpc_pkg::IDX_W-1:0] : '0;

    always_comb begin
        search_ctrl.clear = s_accept;
        search_ctrl.step  = (state_reg == ST_SEARCH) && (cnt_reg != '0);
        search_ctrl.index = cpc_pkg::IDX_W'(cnt_reg - cpc_pkg::CNT_W'(1));
    end

    cpc_palette_store u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     ({s_data.red, s_data.green, s_data.blue}),
        .rd_addr     (rd_addr),
        .rd_data_reg (entry_data)
    );

    cpc_search_unit u_search (
        .aclk           (aclk),
        .ctrl           (search_ctrl),
        .red            (pix_reg.red),
        .green          (pix_reg.green),
        .blue           (pix_reg.blue),
        .entry          (entry_data),
        .best_index_reg (best_index)
    );

    // ---------------- sequencer ----------------
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && (s_data.operation == cpc_pkg::OP_CONVERT)) begin
                    cnt_next = '0;
                    if (mode_reg == cpc_pkg::MODE_PALETTE) begin
                        state_next = ST_SEARCH;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SEARCH: begin
                // last entry is compared in the cycle the count reaches the depth
                if (cnt_reg == cpc_pkg::CNT_W'(cpc_pkg::STORE_DEPTH)) begin
                    state_next = ST_FINISH;
                end else begin
                    cnt_next = cnt_reg + cpc_pkg::CNT_W'(1);
                end
            end
            ST_FINISH: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Pixel and early result held for the length of the word
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pix_reg <= s_data;
            res_reg <= quick_res;
        end
    end

    // ---------------- output register ----------------
    cpc_pkg::result_t final_res;

    always_comb begin
        final_res = res_reg;
        if (mode_reg == cpc_pkg::MODE_PALETTE) begin
            final_res.color_word = {24'd0, cpc_pkg::slot_of_entry(best_index)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= final_res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire
